FILE: sv/fmsr_pkg.sv
// Package of the FM synthesizer register front end.
// Holds the command codes, the result item type and shared widths; no dependencies.
`default_nettype none
package fmsr_pkg;

    localparam int NUM_CHANNELS = 9;
    localparam int CH_W         = 4;
    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_W        = 2;
    localparam int CNT_W        = 3;

    typedef enum logic [3:0] {
        CMD_READ     = 4'd0,
        CMD_WAVE_EN  = 4'd1,
        CMD_MULT     = 4'd2,
        CMD_SUSTAIN  = 4'd3,
        CMD_LEVEL    = 4'd4,
        CMD_ATT_DEC  = 4'd5,
        CMD_SUS_REL  = 4'd6,
        CMD_FREQ     = 4'd7,
        CMD_KEY_ON   = 4'd8,
        CMD_FB_CONN  = 4'd9,
        CMD_WAVEFORM = 4'd10
    } cmd_t;

    localparam logic [7:0] REG_WAVE_EN = 8'h01;
    localparam logic [7:0] REG_TIMER   = 8'h04;
    localparam logic [2:0] GRP_MULT    = 3'd1;
    localparam logic [2:0] GRP_LEVEL   = 3'd2;
    localparam logic [2:0] GRP_ATT_DEC = 3'd3;
    localparam logic [2:0] GRP_SUS_REL = 3'd4;
    localparam logic [2:0] GRP_WAVE    = 3'd7;
    localparam logic [3:0] ROW_FREQ_LO = 4'hA;
    localparam logic [3:0] ROW_FREQ_HI = 4'hB;
    localparam logic [3:0] ROW_FB_CONN = 4'hC;
    localparam logic [4:0] OP_OFF_MAX  = 5'h15;
    localparam logic [7:0] STATUS_IRQ  = 8'hC0;
    localparam logic [7:0] STATUS_IDLE = 8'h00;
    localparam logic [7:0] READ_NONE   = 8'hFF;

    localparam logic [15:0] INDEX_PORT_RST = 16'd904;
    localparam logic [15:0] DATA_PORT_RST  = 16'd905;

    typedef struct packed {
        cmd_t             command;
        logic [CH_W-1:0]  channel;
        logic             is_carrier;
        logic [9:0]       value_a;
        logic [3:0]       value_b;
        logic [7:0]       read_data;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage
`default_nettype wire

FILE: sv/fm_synth_register_front_end_unit.sv
// Top level of the FM synthesizer register front end: input register, port registers,
// decode core and result queue. Depends on fmsr_pkg, fmsr_core and fmsr_res_fifo.
//
//  Channel  Direction  Transfer when           Contents
//  s_       in         s_tvalid && s_tready    bus access
//  m_       out        m_tvalid && m_tready    synthesizer command or read reply
//  cfg_     in         cfg_wr_en               port number registers
//
// An access is taken into the input register and is decoded and queued once the queue has
// room for it; its results then leave from the queue head.
// Results leave the queue one at a time, so an access that yields two commands gives two
// results in turn; at one result per cycle while m_tready is high, m_ sets the sustained rate.
// Reset is synchronous on aresetn low and resets the control state, port registers, latch and queue count.
// A stalled m_ side fills the queue; with more than two entries held, the input register
// keeps its access and s_tready drops.
`default_nettype none
module fm_synth_register_front_end_unit
    import fmsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // port[15:0], write_data[23:16]
    input  wire logic        s_tuser,   // operation[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // channel[3:0], is_carrier[4], value_a[14:5],
                                        // value_b[18:15], read_data[26:19]
    output logic [3:0]       m_tuser,   // command[3:0]
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic             in_valid_reg;
    logic             in_op_reg;
    logic [15:0]      in_port_reg;
    logic [7:0]       in_data_reg;
    logic [15:0]      index_port_reg;
    logic [15:0]      data_port_reg;
    logic             item_go;
    logic             s_take;
    logic             m_take;
    push_t            push;
    result_t          head;
    logic [CNT_W-1:0] fill;

    assign item_go  = in_valid_reg && (fill <= CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || item_go;
    assign s_take   = s_tvalid && s_tready;
    assign m_take   = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            index_port_reg <= INDEX_PORT_RST;
            data_port_reg <= DATA_PORT_RST;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (item_go) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                if (cfg_index) begin
                    data_port_reg <= cfg_wdata;
                end else begin
                    index_port_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_op_reg <= s_tuser;
            in_port_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    fmsr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_go    (item_go),
        .operation  (in_op_reg),
        .port       (in_port_reg),
        .write_data (in_data_reg),
        .index_port (index_port_reg),
        .data_port  (data_port_reg),
        .push       (push)
    );

    fmsr_res_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_take),
        .head_valid (m_tvalid),
        .head       (head),
        .fill       (fill)
    );

    assign m_tdata = {5'd0, head.read_data, head.value_b, head.value_a,
                      head.is_carrier, head.channel};
    assign m_tuser = head.command;
    assign m_tlast = head.last;

endmodule
`default_nettype wire

FILE: sv/fmsr_core.sv
// Register state and single-pass decode of one bus access into up to two commands.
// Depends on fmsr_pkg.
`default_nettype none
module fmsr_core
    import fmsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        item_go,
    input  wire logic        operation,
    input  wire logic [15:0] port,
    input  wire logic [7:0]  write_data,
    input  wire logic [15:0] index_port,
    input  wire logic [15:0] data_port,
    output push_t            push
);

    logic [7:0]  latch_reg, latch_next;
    logic [9:0]  fnum_reg  [NUM_CHANNELS];
    logic [2:0]  block_reg [NUM_CHANNELS];
    logic        armed_reg, armed_next;
    logic        irq_reg, irq_next;

    logic            fnum_we;
    logic [9:0]      fnum_next;
    logic [2:0]      block_next;
    logic [CH_W-1:0] row_ch;
    logic            row_ok;
    logic [2:0]      grp_hi;
    logic [1:0]      op_grp;
    logic [2:0]      op_pos;
    logic            op_ok;
    logic [CH_W-1:0] op_ch;
    logic            op_car;
    logic            irq_seen;
    logic [9:0]      cur_fnum;
    logic [2:0]      cur_block;
    result_t         r0, r1;
    logic [1:0]      n;

    assign grp_hi = latch_reg[7:5];
    assign op_grp = latch_reg[4:3];
    assign op_pos = latch_reg[2:0];
    assign op_ok  = (op_grp != 2'd3) && (op_pos <= 3'd5);
    assign op_car = (op_pos >= 3'd3);
    assign op_ch  = {1'b0, op_grp, 1'b0} + {2'b00, op_grp}
                  + {1'b0, (op_car ? op_pos - 3'd3 : op_pos)};
    assign row_ch = latch_reg[3:0];
    assign row_ok = (row_ch < CH_W'(NUM_CHANNELS));
    assign cur_fnum  = row_ok ? fnum_reg[row_ch]  : 10'd0;
    assign cur_block = row_ok ? block_reg[row_ch] : 3'd0;
    assign irq_seen  = irq_reg | armed_reg;

    always_comb begin
        r0 = '0;
        r1 = '0;
        n = 2'd0;
        latch_next = latch_reg;
        armed_next = armed_reg;
        irq_next = irq_reg;
        fnum_we = 1'b0;
        fnum_next = cur_fnum;
        block_next = cur_block;
        r0.command = CMD_READ;
        r1.command = CMD_READ;
        if (!operation) begin
            n = 2'd1;
            if (port == index_port) begin
                armed_next = 1'b0;
                irq_next = irq_seen;
                r0.read_data = irq_seen ? STATUS_IRQ : STATUS_IDLE;
            end else begin
                r0.read_data = READ_NONE;
            end
        end else if (port == index_port) begin
            latch_next = write_data;
        end else if (port == data_port) begin
            if (latch_reg == REG_WAVE_EN) begin
                n = 2'd1;
                r0.command = CMD_WAVE_EN;
                r0.value_a = {9'd0, write_data[5]};
            end else if (latch_reg == REG_TIMER) begin
                if (write_data[7]) begin
                    irq_next = 1'b0;
                end
                armed_next = write_data[0];
            end else if ((grp_hi == GRP_MULT || grp_hi == GRP_LEVEL || grp_hi == GRP_ATT_DEC
                          || grp_hi == GRP_SUS_REL || grp_hi == GRP_WAVE)
                         && latch_reg[4:0] <= OP_OFF_MAX) begin
                if (op_ok) begin
                    n = 2'd1;
                    r0.channel = op_ch;
                    r0.is_carrier = op_car;
                    r1.channel = op_ch;
                    r1.is_carrier = op_car;
                    case (grp_hi)
                        GRP_MULT: begin
                            n = 2'd2;
                            r0.command = CMD_MULT;
                            r0.value_a = {6'd0, write_data[3:0]};
                            r1.command = CMD_SUSTAIN;
                            r1.value_a = {9'd0, write_data[5]};
                        end
                        GRP_LEVEL: begin
                            r0.command = CMD_LEVEL;
                            r0.value_a = {4'd0, write_data[5:0]};
                        end
                        GRP_ATT_DEC: begin
                            r0.command = CMD_ATT_DEC;
                            r0.value_a = {6'd0, write_data[7:4]};
                            r0.value_b = write_data[3:0];
                        end
                        GRP_SUS_REL: begin
                            r0.command = CMD_SUS_REL;
                            r0.value_a = {6'd0, write_data[7:4]};
                            r0.value_b = write_data[3:0];
                        end
                        default: begin
                            r0.command = CMD_WAVEFORM;
                            r0.value_a = {8'd0, write_data[1:0]};
                        end
                    endcase
                end
            end else if (row_ok && latch_reg[7:4] == ROW_FREQ_LO) begin
                n = 2'd1;
                fnum_we = 1'b1;
                fnum_next = {cur_fnum[9:8], write_data};
                r0.command = CMD_FREQ;
                r0.channel = row_ch;
                r0.value_a = {cur_fnum[9:8], write_data};
                r0.value_b = {1'b0, cur_block};
            end else if (row_ok && latch_reg[7:4] == ROW_FREQ_HI) begin
                n = 2'd2;
                fnum_we = 1'b1;
                fnum_next = {write_data[1:0], cur_fnum[7:0]};
                block_next = write_data[4:2];
                r0.command = CMD_FREQ;
                r0.channel = row_ch;
                r0.value_a = {write_data[1:0], cur_fnum[7:0]};
                r0.value_b = {1'b0, write_data[4:2]};
                r1.command = CMD_KEY_ON;
                r1.channel = row_ch;
                r1.value_a = {9'd0, write_data[5]};
            end else if (row_ok && latch_reg[7:4] == ROW_FB_CONN) begin
                n = 2'd1;
                r0.command = CMD_FB_CONN;
                r0.channel = row_ch;
                r0.value_a = {7'd0, write_data[3:1]};
                r0.value_b = {3'd0, write_data[0]};
            end
        end
        r0.last = (n == 2'd1);
        r1.last = 1'b1;
    end

    assign push.count  = item_go ? n : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg <= '0;
            armed_reg <= 1'b0;
            irq_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                fnum_reg[i] <= '0;
                block_reg[i] <= '0;
            end
        end else if (item_go) begin
            latch_reg <= latch_next;
            armed_reg <= armed_next;
            irq_reg <= irq_next;
            if (fnum_we) begin
                fnum_reg[row_ch] <= fnum_next;
                block_reg[row_ch] <= block_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/fmsr_res_fifo.sv
// Four-entry result queue that takes up to two results per cycle and gives one.
// Depends on fmsr_pkg.
`default_nettype none
module fmsr_res_fifo
    import fmsr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire push_t      push,
    input  wire logic       pop,
    output logic            head_valid,
    output result_t         head,
    output logic [CNT_W-1:0] fill
);

    result_t          entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign wr_ptr_p1  = wr_ptr_reg + PTR_W'(1);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign fill       = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_p1] <= push.second;
        end
    end

endmodule
`default_nettype wire
